// ----- design/rlpt_pkg.sv -----
// Shared types, codes and constants of the refcounted linear probe table.
// No dependencies; every other design file refers to it by scoped names.
package rlpt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BYTES   = 8;
	localparam int HASH_BITS   = 32;
	localparam int MOD_STEPS   = 4;   // remainder bits retired per cycle

	localparam logic [10:0] ACTIVE_RESET = 11'd1024;
	localparam logic [28:0] REF_MAX      = 29'h1FFFFFFF;
	localparam logic [31:0] HASH_MASK    = 32'((64'd1 << HASH_BITS) - 64'd1);

	// register indexes on the config port
	typedef enum logic {
		REG_ACTIVE_SLOTS = 1'b0,
		REG_REF_LIMIT    = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STAT_NEW      = 3'd0,
		STAT_FOUND    = 3'd1,
		STAT_RELEASED = 3'd2,
		STAT_REMOVED  = 3'd3,
		STAT_FULL     = 3'd4,
		STAT_NOTFOUND = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HOME,
		ST_PROBE,
		ST_WREAD,
		ST_WMOD
	} state_t;

	typedef struct packed {
		logic        action;
		logic [63:0] key_value;
		logic [3:0]  key_length;
		logic [31:0] hash_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [28:0] ref_count_after;
		logic        is_stuck;
		logic [10:0] probe_count;
		logic [10:0] live_entries;
		logic [31:0] handle_count;
	} rsp_t;

	// normalized request as queued between front and back
	typedef struct packed {
		op_t         op;
		logic [63:0] key;
		logic [3:0]  len;
		logic [31:0] hash;
	} item_t;

	// one table slot as stored in memory
	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [3:0]  len;
		logic [31:0] hash;
		logic [28:0] refs;
	} slot_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	function automatic logic [63:0] key_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < len) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

// ----- design/rlpt_mod.sv -----
// Iterative remainder unit: dividend mod divisor, MOD_STEPS bits per cycle.
// Depends on rlpt_pkg for the step count.
module rlpt_mod #(
	parameter int DW = 32,
	parameter int NW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] rem
);
	localparam int STEPS = rlpt_pkg::MOD_STEPS;
	localparam int NCYC  = DW / STEPS;
	localparam int CNTW  = $clog2(NCYC + 1);

	logic            busy_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   rem_q, div_q;
	logic [DW-1:0]   dvd_q;
	logic [NW-1:0]   rem_nx;
	logic [DW-1:0]   dvd_nx;

	// restoring steps for one cycle
	always_comb begin
		logic [NW:0] t;
		rem_nx = rem_q;
		dvd_nx = dvd_q;
		for (int i = 0; i < STEPS; i++) begin
			t = {rem_nx, dvd_nx[DW-1]};
			dvd_nx = {dvd_nx[DW-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			rem_nx = t[NW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(NCYC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= dvd_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- design/rlpt_front.sv -----
// Front end: takes requests, clamps length, masks key and hash, classifies the
// operation and queues the result (two entries). Depends on rlpt_pkg.
module rlpt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  rlpt_pkg::req_t      req_data,
	output rlpt_pkg::head_t     head,
	input  logic                pop
);
	rlpt_pkg::item_t q_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	rlpt_pkg::item_t norm;

	// normalize the incoming request
	always_comb begin
		logic [3:0] len;
		len = (req_data.key_length > 4'(rlpt_pkg::KEY_BYTES)) ?
		      4'(rlpt_pkg::KEY_BYTES) : req_data.key_length;
		norm.op   = rlpt_pkg::op_t'(req_data.action);
		norm.len  = len;
		norm.key  = req_data.key_value & rlpt_pkg::key_mask(len);
		norm.hash = req_data.hash_value & rlpt_pkg::HASH_MASK;
	end

	assign req_stall = (cnt_q == 2'd2);
	assign push      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wptr_q] <= norm;
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = q_q[rptr_q];

endmodule

// ----- design/rlpt_back.sv -----
// Back end: slot memory, probe and backward-shift sequencer, statistics and
// result register. Depends on rlpt_pkg and rlpt_mod.
module rlpt_back #(
	parameter int TABLE_DEPTH = rlpt_pkg::TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [10:0]        active_slots,
	input  logic [28:0]        ref_limit,
	input  rlpt_pkg::head_t    head,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rlpt_pkg::rsp_t     rsp_data
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = IW + 1;
	localparam int PW = CW + 1;

	rlpt_pkg::state_t state_q, state_nx;
	rlpt_pkg::slot_t  mem_q [TABLE_DEPTH];
	rlpt_pkg::slot_t  mem_rd_q, w, wdata, word_q;
	rlpt_pkg::item_t  req_q;
	rlpt_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	logic [IW-1:0] clr_q, ix_q, hole_q, n_q, waddr, raddr, ix_nx, n_nx, native;
	logic [CW-1:0] walked_q, a, a_m1, d_n, d_h;
	logic [PW-1:0] pc_q, lp_q, lp_nx;
	logic [CW-1:0] occ_q, occ_nx;
	logic [31:0]   rt_q, rt_nx, sh_q, sh_nx, a32;
	logic [13:0]   kbt_q, kbt_nx;
	logic          we, fin, go_walk, walk_more, mod_start, mod_done, out_free;
	logic          hit, empty, last, stuck_w, far, is_rel;
	logic [28:0]   dec, fin_refs;
	logic          fin_stuck;
	rlpt_pkg::status_t fin_status;
	logic [31:0]   mod_dvd;
	logic [CW-1:0] mod_rem;

	rlpt_mod #(.DW(32), .NW(CW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(mod_dvd),
		.divisor(a), .done(mod_done), .rem(mod_rem)
	);

	// effective slot count, clamped to [4, TABLE_DEPTH]
	always_comb begin
		a32 = {21'd0, active_slots};
		if (a32 < 32'd4) a32 = 32'd4;
		if (a32 > 32'(TABLE_DEPTH)) a32 = 32'(TABLE_DEPTH);
		a    = CW'(a32);
		a_m1 = a - CW'(1);
	end

	// slot examination
	assign w         = mem_rd_q;
	assign is_rel    = (req_q.op == rlpt_pkg::OP_RELEASE);
	assign hit       = w.valid && w.hash == req_q.hash && w.len == req_q.len &&
	                   w.key == req_q.key;
	assign empty     = !w.valid;
	assign last      = (pc_q == PW'(a_m1));
	assign stuck_w   = (w.refs >= ref_limit);
	assign dec       = (w.refs == 29'd0) ? 29'd0 : w.refs - 29'd1;
	assign ix_nx     = ({1'b0, ix_q} + CW'(1) == a) ? '0 : ix_q + IW'(1);
	assign n_nx      = ({1'b0, n_q} + CW'(1) == a) ? '0 : n_q + IW'(1);
	assign walk_more = (walked_q != a_m1) && w.valid;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// forward distances from the native slot of the walked entry
	assign native = mod_rem[IW-1:0];
	assign d_n = (native <= n_q) ? CW'(n_q) - CW'(native) : CW'(n_q) + a - CW'(native);
	assign d_h = (native <= hole_q) ? CW'(hole_q) - CW'(native) :
	             CW'(hole_q) + a - CW'(native);
	assign far = (d_n > d_h);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rlpt_pkg::ST_CLEAR: if (clr_q == IW'(TABLE_DEPTH - 1)) state_nx = rlpt_pkg::ST_IDLE;
			rlpt_pkg::ST_IDLE:  if (pop) state_nx = rlpt_pkg::ST_HOME;
			rlpt_pkg::ST_HOME:  if (mod_done) state_nx = rlpt_pkg::ST_PROBE;
			rlpt_pkg::ST_PROBE: begin
				if (fin) state_nx = rlpt_pkg::ST_IDLE;
				else if (go_walk) state_nx = rlpt_pkg::ST_WREAD;
			end
			rlpt_pkg::ST_WREAD: state_nx = walk_more ? rlpt_pkg::ST_WMOD : rlpt_pkg::ST_IDLE;
			rlpt_pkg::ST_WMOD:  if (mod_done) state_nx = rlpt_pkg::ST_WREAD;
			default:            state_nx = rlpt_pkg::ST_IDLE;
		endcase
	end

	// datapath actions per state
	always_comb begin
		we = 1'b0; waddr = ix_q; wdata = w; raddr = ix_q;
		pop = 1'b0; mod_start = 1'b0; mod_dvd = head.item.hash;
		fin = 1'b0; go_walk = 1'b0;
		fin_status = rlpt_pkg::STAT_NOTFOUND; fin_refs = 29'd0; fin_stuck = 1'b0;
		occ_nx = occ_q; rt_nx = rt_q; sh_nx = sh_q; kbt_nx = kbt_q; lp_nx = lp_q;
		unique case (state_q)
			rlpt_pkg::ST_CLEAR: begin
				we = 1'b1; waddr = clr_q; wdata = '0;
			end
			rlpt_pkg::ST_IDLE: begin
				if (head.valid && out_free) begin
					pop = 1'b1; mod_start = 1'b1;
				end
			end
			rlpt_pkg::ST_HOME: raddr = mod_rem[IW-1:0];
			rlpt_pkg::ST_PROBE: begin
				raddr = ix_nx;
				if (!is_rel && hit) begin
					we = 1'b1;
					wdata.refs = stuck_w ? w.refs : w.refs + 29'd1;
					fin = 1'b1; fin_status = rlpt_pkg::STAT_FOUND;
					fin_refs = wdata.refs; fin_stuck = (wdata.refs >= ref_limit);
					if (rt_q != '1) rt_nx = rt_q + 32'd1;
					if (stuck_w && sh_q != '1) sh_nx = sh_q + 32'd1;
					if (pc_q > lp_q) lp_nx = pc_q;
				end else if (!is_rel && empty) begin
					we = 1'b1;
					wdata = '{valid: 1'b1, key: req_q.key, len: req_q.len,
					          hash: req_q.hash, refs: 29'd1};
					fin = 1'b1; fin_status = rlpt_pkg::STAT_NEW;
					fin_refs = 29'd1; fin_stuck = (29'd1 >= ref_limit);
					occ_nx = occ_q + CW'(1);
					kbt_nx = kbt_q + 14'(req_q.len);
					if (rt_q != '1) rt_nx = rt_q + 32'd1;
					if (pc_q > lp_q) lp_nx = pc_q;
				end else if (!is_rel && last) begin
					fin = 1'b1; fin_status = rlpt_pkg::STAT_FULL;
				end else if (is_rel && hit) begin
					if (rt_q != '0) rt_nx = rt_q - 32'd1;
					if (stuck_w) begin
						fin = 1'b1; fin_status = rlpt_pkg::STAT_RELEASED;
						fin_refs = w.refs; fin_stuck = 1'b1;
					end else if (dec != 29'd0) begin
						we = 1'b1; wdata.refs = dec;
						fin = 1'b1; fin_status = rlpt_pkg::STAT_RELEASED;
						fin_refs = dec; fin_stuck = (dec >= ref_limit);
					end else begin
						go_walk = 1'b1;
						if (occ_q != '0) occ_nx = occ_q - CW'(1);
						kbt_nx = (kbt_q >= 14'(w.len)) ? kbt_q - 14'(w.len) : 14'd0;
					end
				end else if (is_rel && (empty || last)) begin
					fin = 1'b1; fin_status = rlpt_pkg::STAT_NOTFOUND;
				end
			end
			rlpt_pkg::ST_WREAD: begin
				mod_dvd = w.hash;
				if (walk_more) begin
					mod_start = 1'b1;
				end else begin
					// close the final hole
					we = 1'b1; waddr = hole_q; wdata = '0;
					fin = 1'b1; fin_status = rlpt_pkg::STAT_REMOVED;
					if (pc_q > lp_q) lp_nx = pc_q;
				end
			end
			rlpt_pkg::ST_WMOD: begin
				raddr = n_nx;
				if (mod_done && far) begin
					we = 1'b1; waddr = hole_q; wdata = word_q;
				end
			end
			default: ;
		endcase
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		mem_rd_q <= mem_q[raddr];
	end

	// control and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlpt_pkg::ST_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			occ_q       <= '0;
			rt_q        <= '0;
			sh_q        <= '0;
			kbt_q       <= '0;
			lp_q        <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == rlpt_pkg::ST_CLEAR) clr_q <= clr_q + IW'(1);
			occ_q <= occ_nx; rt_q <= rt_nx; sh_q <= sh_nx;
			kbt_q <= kbt_nx; lp_q <= lp_nx;
			if (fin) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// request context and walk pointers
	always_ff @(posedge clk) begin
		if (pop) req_q <= head.item;
		if (state_q == rlpt_pkg::ST_HOME && mod_done) begin
			ix_q <= mod_rem[IW-1:0];
			pc_q <= '0;
		end
		if (state_q == rlpt_pkg::ST_PROBE && !fin) begin
			if (go_walk) begin
				hole_q   <= ix_q;
				n_q      <= ix_nx;
				walked_q <= '0;
			end else begin
				ix_q <= ix_nx;
				pc_q <= pc_q + PW'(1);
			end
		end
		if (state_q == rlpt_pkg::ST_WREAD) word_q <= w;
		if (state_q == rlpt_pkg::ST_WMOD && mod_done) begin
			pc_q     <= pc_q + PW'(1);
			if (far) hole_q <= n_q;
			n_q      <= n_nx;
			walked_q <= walked_q + CW'(1);
		end
		if (fin) begin
			rsp_q <= '{status: fin_status, ref_count_after: fin_refs, is_stuck: fin_stuck,
			           probe_count: 11'(pc_q), live_entries: 11'(occ_nx),
			           handle_count: rt_nx};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rlpt_pkg::ST_CLEAR |-> !rsp_valid_q && !pop)
		else $error("activity during clearing pass");
	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !rsp_valid_q)
		else $error("request started while a result was pending");
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(TABLE_DEPTH))
		else $error("live entry count beyond table depth");
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == rlpt_pkg::ST_PROBE ||
		                       $past(state_q) == rlpt_pkg::ST_WREAD)
		else $error("result raised outside a finishing state");

endmodule

// ----- design/refcounted_linear_probe_table_top.sv -----
// Top level of the refcounted linear probe table: config registers, front end
// and back end. Depends on rlpt_pkg, rlpt_front and rlpt_back.
//
//   channel   direction  handshake            payload
//   request   in         req_valid/req_stall  req_data  (rlpt_pkg::req_t)
//   result    out        rsp_valid/rsp_stall  rsp_data  (rlpt_pkg::rsp_t)
//   config    in         APB psel/penable     paddr, pwdata, prdata
//
// After reset a clearing pass over every slot runs before any request.
// A request probes slots in turn from its home slot, which comes from the
// shared remainder unit (4 bits per cycle). A removal runs the remainder unit
// again for each walked slot of the shift-back scan.
// Up to two requests queue in the front end while the back end works or the
// result is stalled.
module refcounted_linear_probe_table_top #(
	parameter int TABLE_DEPTH = rlpt_pkg::TABLE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  rlpt_pkg::req_t  req_data,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output rlpt_pkg::rsp_t  rsp_data,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);
	logic [10:0]     active_q;
	logic [28:0]     limit_q;
	rlpt_pkg::head_t head;
	logic            pop;
	rlpt_pkg::reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx   = rlpt_pkg::reg_idx_t'(paddr[2]);

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= rlpt_pkg::ACTIVE_RESET;
			limit_q  <= rlpt_pkg::REF_MAX;
		end else if (psel && penable && pwrite && pready) begin
			unique case (ridx)
				rlpt_pkg::REG_ACTIVE_SLOTS: active_q <= pwdata[10:0];
				rlpt_pkg::REG_REF_LIMIT:    limit_q  <= pwdata[28:0];
				default: ;
			endcase
		end
	end

	// readback
	always_comb begin
		unique case (ridx)
			rlpt_pkg::REG_ACTIVE_SLOTS: prdata = {21'd0, active_q};
			rlpt_pkg::REG_REF_LIMIT:    prdata = {3'd0, limit_q};
			default:                    prdata = '0;
		endcase
	end

	rlpt_front u_front (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.req_data(req_data), .head(head), .pop(pop)
	);

	rlpt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .active_slots(active_q), .ref_limit(limit_q),
		.head(head), .pop(pop), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the refcounted linear probe table: directed cases,
// then random acquire/release traffic against an in-bench table model.
// Depends on rlpt_pkg and refcounted_linear_probe_table_top.
module tb;

	localparam int WATCHDOG_LIMIT = 60000;
	localparam int POOL_SIZE      = 20;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	rlpt_pkg::req_t      req_data;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	rlpt_pkg::rsp_t      rsp_data;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	refcounted_linear_probe_table_top u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// table shadow
	bit          tbl_valid [rlpt_pkg::TABLE_DEPTH];
	logic [63:0] tbl_key   [rlpt_pkg::TABLE_DEPTH];
	logic [3:0]  tbl_len   [rlpt_pkg::TABLE_DEPTH];
	logic [31:0] tbl_hash  [rlpt_pkg::TABLE_DEPTH];
	logic [28:0] tbl_refs  [rlpt_pkg::TABLE_DEPTH];
	int unsigned live_cnt;
	logic [31:0] handle_total;
	logic [10:0] cfg_slots;
	logic [28:0] cfg_limit;

	rlpt_pkg::rsp_t pending_rsp[$];
	int          fail_cnt;
	int          tx_idle_pct;
	int          rx_idle_pct;
	int          hold_req;
	int          hold_seen   = 0;
	int          hold_cnt    = 0;
	int          idle_cycles = 0;
	int          sent_cnt;
	int          rsp_cnt;

	// pool of keys reused by random traffic
	rlpt_pkg::req_t key_pool[POOL_SIZE];

	always #5 clk = ~clk;

	function automatic int unsigned slots_used();
		if (cfg_slots < 11'd4) return 4;
		if (cfg_slots > 11'(rlpt_pkg::TABLE_DEPTH)) return rlpt_pkg::TABLE_DEPTH;
		return cfg_slots;
	endfunction

	function automatic logic [63:0] len_mask(input int unsigned len);
		if (len >= 8) return '1;
		return (64'd1 << (8 * len)) - 64'd1;
	endfunction

	function automatic int unsigned ring_dist(input int unsigned from, input int unsigned to,
						  input int unsigned a);
		return (from <= to) ? to - from : to + a - from;
	endfunction

	// apply one request to the shadow table and produce the expected result
	task automatic table_apply(input rlpt_pkg::req_t r, output rlpt_pkg::rsp_t e);
		int unsigned a, len, ix, s, found, empty, probes, hole, n, walked, native;
		logic [63:0] key;
		a      = slots_used();
		len    = (r.key_length > 4'd8) ? 8 : r.key_length;
		key    = r.key_value & len_mask(len);
		ix     = r.hash_value % a;
		found  = a;
		empty  = a;
		probes = a - 1;
		e      = '0;
		for (s = 0; s < a; s++) begin
			if (!tbl_valid[ix]) begin
				empty = ix; probes = s; break;
			end
			if (tbl_hash[ix] == r.hash_value && tbl_len[ix] == len && tbl_key[ix] == key) begin
				found = ix; probes = s; break;
			end
			ix = (ix + 1 == a) ? 0 : ix + 1;
		end
		if (r.action == rlpt_pkg::OP_ACQUIRE) begin
			if (found < a) begin
				if (handle_total != '1) handle_total++;
				if (tbl_refs[found] < cfg_limit) tbl_refs[found]++;
				e.ref_count_after = tbl_refs[found];
				e.is_stuck = tbl_refs[found] >= cfg_limit;
				e.status = rlpt_pkg::STAT_FOUND;
			end else if (empty < a) begin
				tbl_valid[empty] = 1;
				tbl_key[empty]   = key;
				tbl_len[empty]   = len;
				tbl_hash[empty]  = r.hash_value;
				tbl_refs[empty]  = 1;
				live_cnt++;
				if (handle_total != '1) handle_total++;
				e.ref_count_after = 1;
				e.is_stuck = 29'd1 >= cfg_limit;
				e.status = rlpt_pkg::STAT_NEW;
			end else begin
				e.status = rlpt_pkg::STAT_FULL;
			end
		end else if (found < a) begin
			if (handle_total != 0) handle_total--;
			if (tbl_refs[found] >= cfg_limit) begin
				e.ref_count_after = tbl_refs[found];
				e.is_stuck = 1;
				e.status = rlpt_pkg::STAT_RELEASED;
			end else begin
				if (tbl_refs[found] != 0) tbl_refs[found]--;
				e.ref_count_after = tbl_refs[found];
				if (tbl_refs[found] > 0) begin
					e.is_stuck = tbl_refs[found] >= cfg_limit;
					e.status = rlpt_pkg::STAT_RELEASED;
				end else begin
					// removal: shift later cluster members back toward home
					tbl_valid[found] = 0;
					if (live_cnt != 0) live_cnt--;
					hole   = found;
					walked = 0;
					n = (found + 1 == a) ? 0 : found + 1;
					while (walked < a - 1 && tbl_valid[n]) begin
						native = tbl_hash[n] % a;
						probes++;
						if (ring_dist(native, n, a) > ring_dist(native, hole, a)) begin
							tbl_valid[hole] = 1;
							tbl_key[hole]   = tbl_key[n];
							tbl_len[hole]   = tbl_len[n];
							tbl_hash[hole]  = tbl_hash[n];
							tbl_refs[hole]  = tbl_refs[n];
							tbl_valid[n]    = 0;
							hole = n;
						end
						n = (n + 1 == a) ? 0 : n + 1;
						walked++;
					end
					e.status = rlpt_pkg::STAT_REMOVED;
				end
			end
		end else begin
			e.status = rlpt_pkg::STAT_NOTFOUND;
		end
		e.probe_count  = 11'(probes);
		e.live_entries = 11'(live_cnt);
		e.handle_count = handle_total;
	endtask

	task automatic report_mismatch(input string field, input longint unsigned got,
				       input longint unsigned want);
		$display("mismatch on result %0d: %s got %0h expected %0h", rsp_cnt, field, got, want);
		fail_cnt++;
	endtask

	// send one request, optionally idling first; valid stays high between back-to-back sends
	task automatic send_request(input rlpt_pkg::req_t r);
		rlpt_pkg::rsp_t e;
		if ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (req_stall);
		table_apply(r, e);
		pending_rsp.push_back(e);
		sent_cnt++;
	endtask

	task automatic end_burst();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input rlpt_pkg::reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(idx) << 2;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == rlpt_pkg::REG_ACTIVE_SLOTS) cfg_slots = value[10:0];
		else cfg_limit = value[28:0];
	endtask

	function automatic rlpt_pkg::req_t make_req(input rlpt_pkg::op_t op,
						    input logic [63:0] key,
						    input logic [3:0] len,
						    input logic [31:0] hash);
		rlpt_pkg::req_t r;
		r.action     = op;
		r.key_value  = key;
		r.key_length = len;
		r.hash_value = hash;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("unexpected result %0d with nothing pending", rsp_cnt);
				fail_cnt++;
			end else begin
				rlpt_pkg::rsp_t e;
				e = pending_rsp.pop_front();
				if (rsp_data.status != e.status)
					report_mismatch("status", rsp_data.status, e.status);
				if (rsp_data.ref_count_after != e.ref_count_after)
					report_mismatch("ref_count_after", rsp_data.ref_count_after,
							e.ref_count_after);
				if (rsp_data.is_stuck != e.is_stuck)
					report_mismatch("is_stuck", rsp_data.is_stuck, e.is_stuck);
				if (rsp_data.probe_count != e.probe_count)
					report_mismatch("probe_count", rsp_data.probe_count, e.probe_count);
				if (rsp_data.live_entries != e.live_entries)
					report_mismatch("live_entries", rsp_data.live_entries, e.live_entries);
				if (rsp_data.handle_count != e.handle_count)
					report_mismatch("handle_count", rsp_data.handle_count, e.handle_count);
			end
			rsp_cnt++;
		end
	end

	// long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt  <= 300;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// receiver stall
	always @(posedge clk) begin
		rsp_stall <= (hold_cnt > 0) || ($urandom_range(99) < rx_idle_pct);
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results pending", pending_rsp.size());
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// default sizing: collisions, extreme keys, removal with shift-back
	task automatic test_basic_ops();
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h0, 4'd0, 32'h0));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h0, 4'd0, 32'h0));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, '1, 4'd15, '1));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, '1, 4'd8, '1));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'hFFFF_FFFF_FFFF_FF55, 4'd1, 32'h0));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'hAA, 4'd1, 32'd1024));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h55, 4'd2, 32'h0));
		send_request(make_req(rlpt_pkg::OP_RELEASE, 64'h0, 4'd0, 32'h0));
		send_request(make_req(rlpt_pkg::OP_RELEASE, 64'h0, 4'd0, 32'h0));
		send_request(make_req(rlpt_pkg::OP_RELEASE, 64'h0, 4'd0, 32'h0));
		send_request(make_req(rlpt_pkg::OP_RELEASE, 64'h55, 4'd1, 32'h0));
		send_request(make_req(rlpt_pkg::OP_RELEASE, '1, 4'd8, '1));
		end_burst();
	endtask

	// four-slot and full-depth tables: saturation, zero limit, full table, out-of-range sizes
	task automatic test_small_table();
		write_reg(rlpt_pkg::REG_ACTIVE_SLOTS, 32'd0);
		write_reg(rlpt_pkg::REG_REF_LIMIT, 32'd1);
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h11, 4'd1, 32'd4));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h22, 4'd1, 32'd5));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h11, 4'd1, 32'd4));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h33, 4'd3, 32'd2));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h44, 4'd4, 32'd3));
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h55, 4'd5, 32'd7));
		send_request(make_req(rlpt_pkg::OP_RELEASE, 64'h99, 4'd5, 32'd7));
		send_request(make_req(rlpt_pkg::OP_RELEASE, 64'h11, 4'd1, 32'd4));
		end_burst();
		write_reg(rlpt_pkg::REG_REF_LIMIT, 32'd0);
		write_reg(rlpt_pkg::REG_ACTIVE_SLOTS, 32'h7FF);
		send_request(make_req(rlpt_pkg::OP_ACQUIRE, 64'h66, 4'd1, 32'd9));
		send_request(make_req(rlpt_pkg::OP_RELEASE, 64'h66, 4'd1, 32'd9));
		send_request(make_req(rlpt_pkg::OP_RELEASE, 64'h22, 4'd1, 32'd5));
		end_burst();
	endtask

	task automatic fill_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			key_pool[i].action     = rlpt_pkg::OP_ACQUIRE;
			key_pool[i].key_value  = {$urandom, $urandom};
			key_pool[i].key_length = 4'($urandom_range(15));
			key_pool[i].hash_value = $urandom;
		end
	endtask

	// random mix: mostly pool acquire/release, some noise keys
	task automatic test_random_traffic(input int slots, input logic [31:0] limit,
					   input int tx_pct, input int rx_pct, input int count,
					   input bit hold);
		rlpt_pkg::req_t r;
		int pick;
		write_reg(rlpt_pkg::REG_ACTIVE_SLOTS, 32'(slots));
		write_reg(rlpt_pkg::REG_REF_LIMIT, limit);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		fill_pool();
		if (hold) hold_req++;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 90) begin
				r = key_pool[$urandom_range(POOL_SIZE - 1)];
				r.action = (pick < 58) ? rlpt_pkg::OP_ACQUIRE : rlpt_pkg::OP_RELEASE;
			end else begin
				r = make_req(rlpt_pkg::op_t'($urandom_range(1)), {$urandom, $urandom},
					     4'($urandom_range(15)), $urandom);
			end
			send_request(r);
		end
		end_burst();
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       <= 1'b0;
		req_valid    <= 1'b0;
		req_data     <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		fail_cnt     = 0;
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		hold_req     = 0;
		sent_cnt     = 0;
		rsp_cnt      = 0;
		live_cnt     = 0;
		handle_total = '0;
		cfg_slots    = rlpt_pkg::ACTIVE_RESET;
		cfg_limit    = rlpt_pkg::REF_MAX;
		for (int i = 0; i < rlpt_pkg::TABLE_DEPTH; i++) tbl_valid[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_small_table();
		test_random_traffic(16, 32'd3, 37, 74, 210, 1'b0);
		test_random_traffic(64, 32'hFFFF_FFFF, 74, 37, 210, 1'b0);
		test_random_traffic(8, 32'd2, 0, 0, 210, 1'b1);

		$display("covered %0d requests, %0d results: tables of 4 to 1024 slots,", sent_cnt,
			 rsp_cnt);
		$display("limits 0 to max, full table, unknown releases, shift-back removals");
		if (fail_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
